>>> rtl/tgd_pkg.sv
`default_nettype none
package tgd_pkg;

  localparam int GSD_ROUNDS = 3;

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [31:0] TWO_WORD = 32'h4000_0000;
  localparam logic [7:0]  SEED_EXP_TOP = 8'd253;
  localparam int          ALIGN_SHIFT = 39;

  // Reciprocal seed mantissas, indexed by the top seven mantissa bits
  localparam logic [22:0] SEED_ROM [128] = '{
    23'h7f8000, 23'h7e0000, 23'h7c0000, 23'h7a0000,
    23'h780000, 23'h760000, 23'h740000, 23'h720000,
    23'h700000, 23'h6f0000, 23'h6d0000, 23'h6b0000,
    23'h6a0000, 23'h680000, 23'h660000, 23'h650000,
    23'h630000, 23'h610000, 23'h600000, 23'h5e0000,
    23'h5d0000, 23'h5b0000, 23'h5a0000, 23'h590000,
    23'h570000, 23'h560000, 23'h540000, 23'h530000,
    23'h520000, 23'h500000, 23'h4f0000, 23'h4e0000,
    23'h4c0000, 23'h4b0000, 23'h4a0000, 23'h490000,
    23'h470000, 23'h460000, 23'h450000, 23'h440000,
    23'h430000, 23'h410000, 23'h400000, 23'h3f0000,
    23'h3e0000, 23'h3d0000, 23'h3c0000, 23'h3b0000,
    23'h3a0000, 23'h390000, 23'h380000, 23'h370000,
    23'h360000, 23'h350000, 23'h340000, 23'h330000,
    23'h320000, 23'h310000, 23'h300000, 23'h2f0000,
    23'h2e0000, 23'h2d0000, 23'h2c0000, 23'h2b0000,
    23'h2a0000, 23'h290000, 23'h280000, 23'h280000,
    23'h270000, 23'h260000, 23'h250000, 23'h240000,
    23'h230000, 23'h230000, 23'h220000, 23'h210000,
    23'h200000, 23'h1f0000, 23'h1f0000, 23'h1e0000,
    23'h1d0000, 23'h1c0000, 23'h1c0000, 23'h1b0000,
    23'h1a0000, 23'h190000, 23'h190000, 23'h180000,
    23'h170000, 23'h170000, 23'h160000, 23'h150000,
    23'h140000, 23'h140000, 23'h130000, 23'h120000,
    23'h120000, 23'h110000, 23'h100000, 23'h100000,
    23'h0f0000, 23'h0f0000, 23'h0e0000, 23'h0d0000,
    23'h0d0000, 23'h0c0000, 23'h0c0000, 23'h0b0000,
    23'h0a0000, 23'h0a0000, 23'h090000, 23'h090000,
    23'h080000, 23'h070000, 23'h070000, 23'h060000,
    23'h060000, 23'h050000, 23'h050000, 23'h040000,
    23'h040000, 23'h030000, 23'h030000, 23'h020000,
    23'h020000, 23'h010000, 23'h010000, 23'h000000
  };

  // Aligned difference waiting for normalization
  typedef struct packed {
    logic [63:0] diff;
    logic        sgn;
    logic [7:0]  bexp;
    logic        direct;
    logic [31:0] word;
    logic        bad;
  } align_t;

  // Per-item context carried down the pipe
  typedef struct packed {
    logic        op;
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] d;
    logic [31:0] n;
    logic [31:0] t;
    logic        bad;
    logic        rbad;
    align_t      al;
  } ctx_t;

  function automatic logic is_zero(input logic [31:0] w);
    return w[30:0] == 31'd0;
  endfunction

  function automatic logic is_normal(input logic [31:0] w);
    return (w[30:23] != 8'h00) && (w[30:23] != 8'hff);
  endfunction

endpackage
`default_nettype wire

>>> rtl/tgd_req_if.sv
`default_nettype none
interface tgd_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] numerator;
  logic [31:0] denominator;

  modport source (output valid, output op, output numerator, output denominator,
                  input ready);
  modport sink (input valid, input op, input numerator, input denominator,
                output ready);
endinterface
`default_nettype wire

>>> rtl/tgd_rsp_if.sv
`default_nettype none
interface tgd_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        out_of_domain;

  modport source (output valid, output result, output out_of_domain, input ready);
  modport sink (input valid, input result, input out_of_domain, output ready);
endinterface
`default_nettype wire

>>> rtl/truncating_goldschmidt_divider_core.sv
`default_nettype none
// Throughput: one word per cycle; each stage holds while the stage after it is full
// and stalled, so empty stages still fill behind a waiting result, and once every
// stage is full the stall reaches the input.
// Stages: seed lookup, scaling, per round a two-stage truncating subtract and a multiply; residual mul and sub.
// Reset: rst clears every stage valid bit synchronously; payload is not reset.
module truncating_goldschmidt_divider_core
  import tgd_pkg::*;
#(
  parameter int ROUNDS = GSD_ROUNDS
) (
  input  wire logic clk,
  input  wire logic rst,
  tgd_req_if.sink   req,
  tgd_rsp_if.source rsp
);

  localparam int NS      = 5 + 3 * ROUNDS;
  localparam int RES_MUL = 2 + 3 * ROUNDS;

  ctx_t          ctx_q [NS];
  logic [NS-1:0] v;
  logic [NS:0]   en;
  ctx_t          fin;
  logic          fin_bad;

  // A stage takes a new word when it is empty or its content moves on
  assign en[NS] = rsp.ready;
  assign req.ready = en[0];

  for (genvar s = 0; s < NS; s++) begin : gen_stage
    ctx_t ctx_next;
    logic v_in;

    assign en[s] = !v[s] || en[s+1];

    if (s == 0) begin : gen_seed
      logic [31:0] x;
      tgd_seed u_seed (.den(req.denominator), .x(x));
      assign v_in = req.valid;
      always_comb begin
        ctx_next      = '0;
        ctx_next.op   = req.op;
        ctx_next.num  = req.numerator;
        ctx_next.den  = req.denominator;
        ctx_next.t    = x;
        ctx_next.bad  = (!is_normal(req.numerator) && !is_zero(req.numerator))
                     || (!is_normal(req.denominator) && !is_zero(req.denominator));
        ctx_next.rbad = 1'b0;
      end
    end else begin : gen_work
      assign v_in = v[s-1];
      if (s == 1) begin : gen_init
        // Scale both operands by the seed
        logic [31:0] yd, yn;
        logic        bd, bn;
        tgd_tmul u_md (.a(ctx_q[s-1].t), .b(ctx_q[s-1].den), .y(yd), .bad(bd));
        tgd_tmul u_mn (.a(ctx_q[s-1].t), .b(ctx_q[s-1].num), .y(yn), .bad(bn));
        always_comb begin
          ctx_next     = ctx_q[s-1];
          ctx_next.d   = yd;
          ctx_next.n   = yn;
          ctx_next.bad = ctx_q[s-1].bad | bd | bn;
        end
      end else if (s < RES_MUL && (s - 2) % 3 == 0) begin : gen_ralign
        // Line up two minus d
        align_t al;
        tgd_sub_align u_al (.a(TWO_WORD), .b(ctx_q[s-1].d), .al(al));
        always_comb begin
          ctx_next    = ctx_q[s-1];
          ctx_next.al = al;
        end
      end else if (s < RES_MUL && (s - 2) % 3 == 1) begin : gen_rnorm
        logic [31:0] y;
        logic        b;
        tgd_sub_norm u_nm (.al(ctx_q[s-1].al), .y(y), .bad(b));
        always_comb begin
          ctx_next     = ctx_q[s-1];
          ctx_next.t   = y;
          ctx_next.bad = ctx_q[s-1].bad | b;
        end
      end else if (s < RES_MUL) begin : gen_rmul
        // Advance both d and n by the correction factor
        logic [31:0] yd, yn;
        logic        bd, bn;
        tgd_tmul u_md (.a(ctx_q[s-1].t), .b(ctx_q[s-1].d), .y(yd), .bad(bd));
        tgd_tmul u_mn (.a(ctx_q[s-1].t), .b(ctx_q[s-1].n), .y(yn), .bad(bn));
        always_comb begin
          ctx_next     = ctx_q[s-1];
          ctx_next.d   = yd;
          ctx_next.n   = yn;
          ctx_next.bad = ctx_q[s-1].bad | bd | bn;
        end
      end else if (s == RES_MUL) begin : gen_qmul
        // Form q times the denominator for the residual
        logic [31:0] y;
        logic        b;
        tgd_tmul u_mq (.a(ctx_q[s-1].n), .b(ctx_q[s-1].den), .y(y), .bad(b));
        always_comb begin
          ctx_next      = ctx_q[s-1];
          ctx_next.t    = y;
          ctx_next.rbad = ctx_q[s-1].rbad | b;
        end
      end else if (s == RES_MUL + 1) begin : gen_qalign
        align_t al;
        tgd_sub_align u_al (.a(ctx_q[s-1].num), .b(ctx_q[s-1].t), .al(al));
        always_comb begin
          ctx_next    = ctx_q[s-1];
          ctx_next.al = al;
        end
      end else begin : gen_qnorm
        logic [31:0] y;
        logic        b;
        tgd_sub_norm u_nm (.al(ctx_q[s-1].al), .y(y), .bad(b));
        always_comb begin
          ctx_next      = ctx_q[s-1];
          ctx_next.t    = y;
          ctx_next.rbad = ctx_q[s-1].rbad | b;
        end
      end
    end

    // Hold on stall, advance otherwise
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en[s]) begin
        v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        ctx_q[s] <= ctx_next;
      end
    end
  end

  // Pick quotient or residual; drop the value when out of domain
  assign fin     = ctx_q[NS-1];
  assign fin_bad = fin.bad | (fin.op & fin.rbad);

  assign rsp.valid         = v[NS-1];
  assign rsp.out_of_domain = fin_bad;
  assign rsp.result        = fin_bad ? 32'd0 : (fin.op ? fin.t : fin.n);

endmodule
`default_nettype wire

>>> rtl/tgd_seed.sv
`default_nettype none
module tgd_seed
  import tgd_pkg::*;
(
  input  wire logic [31:0] den,
  output logic      [31:0] x
);

  logic [7:0] f;

  // Look up the reciprocal seed; out-of-range exponents give a signed zero
  always_comb begin
    f = den[30:23];
    if (f == 8'd0 || f >= SEED_EXP_TOP) begin
      x = {den[31], 31'd0};
    end else begin
      x = {den[31], 8'(SEED_EXP_TOP - f), SEED_ROM[den[22:16]]};
    end
  end

endmodule
`default_nettype wire

>>> rtl/tgd_tmul.sv
`default_nettype none
module tgd_tmul
  import tgd_pkg::*;
(
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y,
  output logic             bad
);

  logic [47:0]       p;
  logic signed [9:0] ev;
  logic [22:0]       mant;
  logic              sgn;

  assign p = {1'b1, a[22:0]} * {1'b1, b[22:0]};

  // Truncate the product to 24 bits and pack
  always_comb begin
    sgn  = a[31] ^ b[31];
    ev   = $signed({2'b0, a[30:23]}) + $signed({2'b0, b[30:23]}) - 10'sd127
         + $signed({9'b0, p[47]});
    mant = p[47] ? p[46:24] : p[45:23];
    y    = 32'd0;
    bad  = 1'b0;
    if (is_zero(a) || is_zero(b)) begin
      y = {sgn, 31'd0};
    end else if (!is_normal(a) || !is_normal(b)) begin
      bad = 1'b1;
    end else if (ev <= 10'sd0 || ev >= 10'sd255) begin
      bad = 1'b1;
    end else begin
      y = {sgn, ev[7:0], mant};
    end
  end

endmodule
`default_nettype wire

>>> rtl/tgd_sub_align.sv
`default_nettype none
module tgd_sub_align
  import tgd_pkg::*;
(
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output align_t           al
);

  logic        sa, sb, agb;
  logic [23:0] big, little;
  logic [7:0]  gap;
  logic [63:0] bigx, part;

  // Order the operands by magnitude and line up the smaller one
  always_comb begin
    sa     = a[31];
    sb     = ~b[31];
    agb    = a[30:0] >= b[30:0];
    big    = agb ? {1'b1, a[22:0]} : {1'b1, b[22:0]};
    little = agb ? {1'b1, b[22:0]} : {1'b1, a[22:0]};
    gap    = agb ? (a[30:23] - b[30:23]) : (b[30:23] - a[30:23]);
    bigx   = {1'b0, big, 39'd0};
    if (gap >= 8'd63) begin
      part = (sa != sb) ? 64'd1 : 64'd0;
    end else begin
      part = {1'b0, little, 39'd0} >> gap;
    end
    al.diff   = (sa == sb) ? (bigx + part) : (bigx - part);
    al.sgn    = agb ? sa : sb;
    al.bexp   = agb ? a[30:23] : b[30:23];
    al.direct = 1'b0;
    al.word   = 32'd0;
    al.bad    = 1'b0;
    if ((!is_normal(a) && !is_zero(a)) || (!is_normal(b) && !is_zero(b))) begin
      al.direct = 1'b1;
      al.bad    = 1'b1;
    end else if (is_zero(b)) begin
      al.direct = 1'b1;
      if (is_zero(a)) begin
        al.word = (a[31] && !b[31]) ? SIGN_BIT : 32'd0;
      end else begin
        al.word = a;
      end
    end else if (is_zero(a)) begin
      al.direct = 1'b1;
      al.word   = b ^ SIGN_BIT;
    end
  end

endmodule
`default_nettype wire

>>> rtl/tgd_sub_norm.sv
`default_nettype none
module tgd_sub_norm
  import tgd_pkg::*;
(
  input  wire align_t      al,
  output logic      [31:0] y,
  output logic             bad
);

  logic [5:0]        lz;
  logic [63:0]       norm;
  logic signed [9:0] ev;

  // Count leading zeros of the difference
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (al.diff[i]) begin
        lz = 6'(63 - i);
      end
    end
  end

  // Normalize, truncate and pack with range checks
  always_comb begin
    norm = al.diff << lz;
    ev   = $signed({2'b0, al.bexp}) + 10'sd1 - $signed({4'b0, lz});
    y    = 32'd0;
    bad  = 1'b0;
    if (al.direct) begin
      y   = al.word;
      bad = al.bad;
    end else if (al.diff == 64'd0) begin
      y = 32'd0;
    end else if (ev <= 10'sd0) begin
      y = {al.sgn, 31'd0};
    end else if (ev >= 10'sd255) begin
      bad = 1'b1;
    end else begin
      y = {al.sgn, ev[7:0], norm[62:40]};
    end
  end

endmodule
`default_nettype wire

>>> verif/tgd_div_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module tgd_div_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire logic        req_ready,
  input  wire logic        req_op,
  input  wire logic [31:0] req_numerator,
  input  wire logic [31:0] req_denominator,
  input  wire logic        rsp_valid,
  input  wire logic        rsp_ready,
  input  wire logic [31:0] rsp_result,
  input  wire logic        rsp_out_of_domain,
  output int               errors,
  output int               pending
);
  import tgd_pkg::*;

  typedef struct packed {
    logic [31:0] result;
    logic        ood;
  } div_result_t;

  div_result_t expected_q[$];

  function automatic logic fzero(logic [31:0] w);
    return w[30:0] == 31'd0;
  endfunction

  function automatic logic fnormal(logic [31:0] w);
    return (w[30:23] != 8'h00) && (w[30:23] != 8'hff);
  endfunction

  function automatic logic [31:0] sig24(logic [31:0] w);
    return {8'd0, 1'b1, w[22:0]};
  endfunction

  // Pack a difference: flush underflow to signed zero, flag overflow
  function automatic logic [31:0] pack_diff(logic sgn, int e, logic [31:0] sig,
                                            ref logic bad);
    if (e + 127 <= 0) return {sgn, 31'd0};
    if (e + 127 >= 255) begin
      bad = 1'b1;
      return 32'd0;
    end
    return {sgn, 8'(e + 127), sig[22:0]};
  endfunction

  // Truncating multiply
  function automatic logic [31:0] trunc_mul(logic [31:0] a, logic [31:0] b, ref logic bad);
    logic [63:0] p;
    logic [31:0] sig;
    int e;
    if (fzero(a) || fzero(b)) return {a[31] ^ b[31], 31'd0};
    if (!fnormal(a) || !fnormal(b)) begin
      bad = 1'b1;
      return 32'd0;
    end
    p = 64'(sig24(a)) * 64'(sig24(b));
    e = int'(a[30:23]) + int'(b[30:23]) - 254;
    if (p[47]) begin
      sig = p[55:24];
      e = e + 1;
    end else begin
      sig = p[54:23];
    end
    if (e + 127 <= 0 || e + 127 >= 255) begin
      bad = 1'b1;
      return 32'd0;
    end
    return {a[31] ^ b[31], 8'(e + 127), sig[22:0]};
  endfunction

  // Truncating subtract a - b
  function automatic logic [31:0] trunc_sub(logic [31:0] a, logic [31:0] b, ref logic bad);
    logic sa, sb, sgn;
    logic [31:0] big, lit, sig;
    int ea, eb, bexp, gap, top;
    logic [63:0] diff, part;
    if ((!fnormal(a) && !fzero(a)) || (!fnormal(b) && !fzero(b))) begin
      bad = 1'b1;
      return 32'd0;
    end
    if (fzero(b)) begin
      if (fzero(a)) return (a[31] && !b[31]) ? SIGN_BIT : 32'd0;
      return a;
    end
    if (fzero(a)) return b ^ SIGN_BIT;
    sa = a[31];
    sb = ~b[31];
    ea = int'(a[30:23]) - 127;
    eb = int'(b[30:23]) - 127;
    if (ea > eb || (ea == eb && sig24(a) >= sig24(b))) begin
      big = sig24(a); lit = sig24(b); bexp = ea; gap = ea - eb; sgn = sa;
    end else begin
      big = sig24(b); lit = sig24(a); bexp = eb; gap = eb - ea; sgn = sb;
    end
    part = (gap >= 64) ? 64'd0 : ((64'(lit) << 39) >> gap);
    if (sa == sb) begin
      diff = (64'(big) << 39) + part;
    end else begin
      if (gap >= 63) begin
        if (big == 32'h80_0000) return pack_diff(sgn, bexp - 1, 32'hff_ffff, bad);
        return pack_diff(sgn, bexp, big - 1, bad);
      end
      diff = (64'(big) << 39) - part;
    end
    if (diff == 64'd0) return 32'd0;
    top = 63;
    while (!diff[top]) top = top - 1;
    if (top >= 23) sig = 32'(diff >> (top - 23));
    else sig = 32'(diff << (23 - top));
    return pack_diff(sgn, bexp + top - 62, sig, bad);
  endfunction

  function automatic div_result_t predict_divide(logic op, logic [31:0] num,
                                                 logic [31:0] den);
    div_result_t r;
    logic bad;
    logic [31:0] x, d, n, e2;
    int re;
    bad = 1'b0;
    r.result = 32'd0;
    if ((!fnormal(num) && !fzero(num)) || (!fnormal(den) && !fzero(den))) begin
      bad = 1'b1;
    end else begin
      // Reciprocal seed from the mantissa table
      re = 126 - int'(den[30:23]);
      if (re > 125 || re < -126) x = {den[31], 31'd0};
      else x = {den[31], 8'(re + 127), SEED_ROM[den[22:16]]};
      d = trunc_mul(x, den, bad);
      n = trunc_mul(x, num, bad);
      for (int i = 0; i < GSD_ROUNDS; i++) begin
        e2 = trunc_sub(TWO_WORD, d, bad);
        d = trunc_mul(e2, d, bad);
        n = trunc_mul(e2, n, bad);
      end
      r.result = n;
      if (op && !bad) r.result = trunc_sub(num, trunc_mul(n, den, bad), bad);
    end
    if (bad) r.result = 32'd0;
    r.ood = bad;
    return r;
  endfunction

  assign pending = expected_q.size();

  // Predict on accepted requests, compare on accepted responses
  always @(posedge clk) begin
    div_result_t exp_r;
    int          nerr;
    nerr = 0;
    if (!rst) begin
      if (req_valid && req_ready)
        expected_q.push_back(predict_divide(req_op, req_numerator, req_denominator));
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected word: result=%h out_of_domain=%b", rsp_result,
                 rsp_out_of_domain);
          nerr = nerr + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (rsp_result !== exp_r.result) begin
            $error("result: expected %h actual %h", exp_r.result, rsp_result);
            nerr = nerr + 1;
          end
          if (rsp_out_of_domain !== exp_r.ood) begin
            $error("out_of_domain: expected %b actual %b", exp_r.ood, rsp_out_of_domain);
            nerr = nerr + 1;
          end
        end
      end
    end
    if (nerr != 0) errors <= errors + nerr;
  end

  initial errors = 0;
endmodule
`default_nettype wire

>>> verif/tb_truncating_goldschmidt_divider_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_truncating_goldschmidt_divider_core;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 1680;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  int   stall_cycles = 0;
  logic running = 1'b1;

  tgd_req_if req ();
  tgd_rsp_if rsp ();

  truncating_goldschmidt_divider_core dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  tgd_div_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready), .req_op(req.op),
    .req_numerator(req.numerator), .req_denominator(req.denominator),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_result(rsp.result),
    .rsp_out_of_domain(rsp.out_of_domain), .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random operand: mostly normal values near each other, some zeros and odd encodings
  function automatic logic [31:0] rand_float(logic [7:0] ebase);
    int p;
    p = $urandom_range(0, 99);
    if (p < 75) return {1'($urandom), 8'(int'(ebase) + $urandom_range(0, 12) - 6),
                        23'($urandom)};
    if (p < 83) return {1'($urandom), 31'd0};
    if (p < 88) return {1'($urandom), 8'hff, 23'($urandom_range(0, 1) ? $urandom : 0)};
    if (p < 92) return {1'($urandom), 8'h00, 23'($urandom)};
    return $urandom;
  endfunction

  // Random response back-pressure, with quiet stretches
  initial begin
    int g;
    rsp.ready = 1'b0;
    @(posedge clk);
    forever begin
      rsp.ready <= 1'b1;
      g = gap_len();
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (g > 0) begin
        rsp.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic send_word(logic op, logic [31:0] num, logic [31:0] den);
    int g;
    g = gap_len();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.numerator <= num;
    req.denominator <= den;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Watchdog on accepted words in either direction
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (running && stall_cycles >= STALL_LIMIT) begin
      $display("[truncating_goldschmidt_divider_core] ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] dir_num [12];
    logic [31:0] dir_den [12];
    logic [7:0]  eb;
    dir_num = '{32'h3f80_0000, 32'h4040_0000, 32'h0000_0000, 32'h8000_0000,
                32'h7f7f_ffff, 32'h0080_0000, 32'h7f80_0000, 32'h0000_0001,
                32'h7fc0_0000, 32'hc2f6_e979, 32'h3f80_0000, 32'h3f80_0000};
    dir_den = '{32'h3f80_0000, 32'h3fff_ffff, 32'h4000_0000, 32'h0000_0000,
                32'h0080_0000, 32'h7f7f_ffff, 32'h3f80_0000, 32'h3f80_0000,
                32'h4000_0000, 32'hbfc0_0000, 32'h7f00_0000, 32'h8000_0000};
    req.valid = 1'b0;
    req.op = 1'b0;
    req.numerator = 32'd0;
    req.denominator = 32'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, zeros, special encodings, both operations
    for (int i = 0; i < 12; i++) begin
      send_word(1'b0, dir_num[i], dir_den[i]);
      send_word(1'b1, dir_num[i], dir_den[i]);
    end
    send_word(1'b1, 32'hffff_ffff, 32'hffff_ffff);

    // Hold off until the pipe is empty once
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      eb = (i % 8 == 0) ? 8'($urandom_range(7, 248)) : 8'($urandom_range(100, 154));
      send_word(1'($urandom), rand_float(eb), rand_float(eb));
    end
    req.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    running = 1'b0;
    if (errors == 0) $display("[truncating_goldschmidt_divider_core] OK");
    else $display("[truncating_goldschmidt_divider_core] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
